@@ rtl/core/fahc_pkg.sv @@
// ----------------------------------------------------------------------------
// fahc_pkg: shared types for the associative handle cache
// Input and result words, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package fahc_pkg;

	localparam int KEY_VARIANT_W  = 8;
	localparam int KEY_IDENTITY_W = 32;
	localparam int HANDLE_W       = 32;
	localparam int COUNT_W        = 32;
	localparam int OCC_OUT_W      = 5;
	localparam int SLOTS_CFG_W    = 5;

	// Operation codes carried in the input word.
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_FLUSH   = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic [KEY_VARIANT_W-1:0]  key_variant;
		logic [KEY_IDENTITY_W-1:0] key_identity;
		logic                      create_ok;
		logic [HANDLE_W-1:0]       new_handle;
	} item_t;

	typedef struct packed {
		logic                 success;
		logic                 was_hit;
		logic [HANDLE_W-1:0]  handle_out;
		logic                 released_valid;
		logic [HANDLE_W-1:0]  released_handle;
		logic                 last_result;
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   miss_total;
		logic [COUNT_W-1:0]   eviction_total;
		logic [COUNT_W-1:0]   failure_total;
		logic [OCC_OUT_W-1:0] occupied_total;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // latch the input word
		logic acq;       // perform the lookup and update of an acquire
		logic fls_step;  // release one slot of a flush (or report an empty cache)
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic occ_zero;  // no slot occupied
		logic fls_last;  // the flush index points at the last occupied slot
	} sts_t;

endpackage

@@ rtl/core/fifo_assoc_handle_cache.sv @@
// ----------------------------------------------------------------------------
// fifo_assoc_handle_cache: associative key-to-handle cache, oldest-first eviction
// An accepted acquire runs its compare in the ACQ state; done and the result
// word are registered from it. A new word can be taken while that result is
// shown, but not during the compare. A flush is busy while it walks the
// occupied slots (one step if empty) and takes no new word until it ends.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears all slots, the pointer and counters; slots in use returns to
// the built capacity. Key and handle storage is not cleared.
// ----------------------------------------------------------------------------
module fifo_assoc_handle_cache #(
	parameter int CAPACITY      = 16,
	parameter int IDENTITY_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  fahc_pkg::item_t                  item,
	output logic                             done,
	output fahc_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [fahc_pkg::SLOTS_CFG_W-1:0] cfg_wdata
);
	import fahc_pkg::*;

	// The controller decides when a word is taken and walks a flush across the
	// occupied slots; the datapath holds every piece of cache state.
	cmd_t cmd;
	sts_t sts;

	fahc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// An acquire compares the key against all slots at once in the cycle after
	// acceptance, updates storage and counters at its end, and the result word
	// is shown in the following cycle while the next word may already be taken.
	// A flush reads one slot per cycle, its results registered from those reads,
	// and the sweep ends at the last occupied slot, or at once if none is held.
	fahc_dp #(
		.CAPACITY      (CAPACITY),
		.IDENTITY_BITS (IDENTITY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule

@@ rtl/core/fahc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fahc_ctrl: sequencing controller
// Accepts a word, then runs the acquire state or a flush sweep over the
// occupied slots, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module fahc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          operation,
	input  fahc_pkg::sts_t sts,
	output fahc_pkg::cmd_t cmd,
	output logic          busy
);
	import fahc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACQ  = 2'd1;
	localparam logic [1:0] ST_FLS  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d      = state_q;
		cmd.load     = accept;
		cmd.acq      = 1'b0;
		cmd.fls_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_FLUSH) ? ST_FLS : ST_ACQ;
				end
			end
			ST_ACQ: begin
				cmd.acq = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FLS: begin
				cmd.fls_step = 1'b1;
				if (sts.occ_zero || sts.fls_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/fahc_dp.sv @@
// ----------------------------------------------------------------------------
// fahc_dp: cache datapath
// Key registers with parallel compare, handle memory, replace pointer,
// statistics counters and the registered result word.
// ----------------------------------------------------------------------------
module fahc_dp #(
	parameter int CAPACITY      = 16,
	parameter int IDENTITY_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fahc_pkg::cmd_t                      cmd,
	output fahc_pkg::sts_t                      sts,
	input  fahc_pkg::item_t                     item,
	input  logic                                cfg_we,
	input  logic [fahc_pkg::SLOTS_CFG_W-1:0]    cfg_wdata,
	output logic                                done,
	output fahc_pkg::result_t                   result
);
	import fahc_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KB = (IDENTITY_BITS < KEY_IDENTITY_W) ? IDENTITY_BITS : KEY_IDENTITY_W;
	localparam int XW = 8;   // common width for compares of counts and slots

	item_t                      item_q;
	logic [KEY_VARIANT_W-1:0]   key_var_q [CAPACITY];
	logic [KB-1:0]              key_id_q  [CAPACITY];
	logic [HANDLE_W-1:0]        hmem      [CAPACITY];
	logic [HANDLE_W-1:0]        rd_q;
	logic [CAPACITY-1:0]        valid_q;
	logic [CW-1:0]              occ_q;
	logic [CW-1:0]              slots_q;
	logic [IW-1:0]              ptr_q;
	logic [IW-1:0]              fls_idx_q;
	logic [COUNT_W-1:0]         hit_cnt_q;
	logic [COUNT_W-1:0]         miss_cnt_q;
	logic [COUNT_W-1:0]         evict_cnt_q;
	logic [COUNT_W-1:0]         fail_cnt_q;
	logic                       done_s2;
	logic                       res_success_s2;
	logic                       res_hit_s2;
	logic                       res_rel_s2;
	logic                       res_last_s2;
	logic                       res_flush_s2;
	logic [HANDLE_W-1:0]        res_nh_s2;

	logic [CAPACITY-1:0]        match;
	logic                       hit;
	logic [IW-1:0]              hit_idx;
	logic [KB-1:0]              ident;
	logic [XW-1:0]              occ_x;
	logic [XW-1:0]              slots_x;
	logic [XW-1:0]              ptr_x;
	logic [XW-1:0]              nxt_ptr_x;
	logic [XW-1:0]              cfg_x;
	logic [XW-1:0]              cfg_clamp;
	logic                       full;
	logic [IW-1:0]              ptr_slot;
	logic [IW-1:0]              ins_slot;
	logic [IW-1:0]              nxt_ptr;
	logic [IW-1:0]              rd_addr;
	logic                       ins;
	logic                       fls_end;
	logic [XW-1:0]              occ_out_x;

	assign ident   = item_q.key_identity[KB-1:0];
	assign occ_x   = XW'(occ_q);
	assign slots_x = XW'(slots_q);
	assign ptr_x   = XW'(ptr_q);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = valid_q[i] && (key_var_q[i] == item_q.key_variant) &&
				(key_id_q[i] == ident);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	assign hit       = |match;
	assign full      = (occ_x >= slots_x);
	assign ptr_slot  = (ptr_x >= slots_x) ? '0 : ptr_q;
	assign ins_slot  = full ? ptr_slot : IW'(occ_q);
	assign nxt_ptr_x = XW'(ptr_slot) + XW'(1);
	assign nxt_ptr   = (nxt_ptr_x >= slots_x) ? '0 : IW'(nxt_ptr_x);
	assign ins       = cmd.acq && !hit && item_q.create_ok;
	assign rd_addr   = cmd.fls_step ? fls_idx_q : (hit ? hit_idx : ins_slot);

	assign sts.occ_zero = (occ_q == '0);
	assign sts.fls_last = ((XW'(fls_idx_q) + XW'(1)) == occ_x);
	assign fls_end      = cmd.fls_step && (sts.occ_zero || sts.fls_last);

	// A zero slot count is taken as one, anything above the built size as the size.
	assign cfg_x     = XW'(cfg_wdata);
	assign cfg_clamp = (cfg_x == '0) ? XW'(1) :
		((cfg_x > XW'(CAPACITY)) ? XW'(CAPACITY) : cfg_x);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// Handle memory: registered read, old data returned when the same slot is
	// rewritten, which is what an eviction needs.
	always_ff @(posedge clk) begin
		rd_q <= hmem[rd_addr];
		if (ins) begin
			hmem[ins_slot] <= item_q.new_handle;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			key_var_q[ins_slot] <= item_q.key_variant;
			key_id_q[ins_slot]  <= ident;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			slots_q     <= CW'(CAPACITY);
			ptr_q       <= '0;
			fls_idx_q   <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			fail_cnt_q  <= '0;
			done_s2     <= 1'b0;
		end else begin
			done_s2 <= cmd.acq || cmd.fls_step;
			if (cfg_we && sts.occ_zero) begin
				slots_q <= CW'(cfg_clamp);
				ptr_q   <= '0;
			end
			if (cmd.load) begin
				fls_idx_q <= '0;
			end
			if (cmd.acq) begin
				if (hit) begin
					hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
				end else if (item_q.create_ok) begin
					miss_cnt_q          <= miss_cnt_q + COUNT_W'(1);
					valid_q[ins_slot]   <= 1'b1;
					if (full) begin
						evict_cnt_q <= evict_cnt_q + COUNT_W'(1);
						ptr_q       <= nxt_ptr;
					end else begin
						occ_q <= occ_q + CW'(1);
					end
				end else begin
					fail_cnt_q <= fail_cnt_q + COUNT_W'(1);
				end
			end
			if (cmd.fls_step) begin
				if (fls_end) begin
					valid_q   <= '0;
					occ_q     <= '0;
					ptr_q     <= '0;
					fls_idx_q <= '0;
				end else begin
					fls_idx_q <= fls_idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fls_step) begin
			res_success_s2 <= 1'b0;
			res_hit_s2     <= 1'b0;
			res_rel_s2     <= !sts.occ_zero;
			res_last_s2    <= fls_end;
			res_flush_s2   <= 1'b1;
			res_nh_s2      <= '0;
		end else begin
			res_success_s2 <= hit || item_q.create_ok;
			res_hit_s2     <= hit;
			res_rel_s2     <= ins && full;
			res_last_s2    <= 1'b1;
			res_flush_s2   <= 1'b0;
			res_nh_s2      <= ins ? item_q.new_handle : '0;
		end
	end

	assign occ_out_x = res_flush_s2 ? '0 : occ_x;

	assign done                   = done_s2;
	assign result.success         = res_success_s2;
	assign result.was_hit         = res_hit_s2;
	assign result.handle_out      = res_hit_s2 ? rd_q : res_nh_s2;
	assign result.released_valid  = res_rel_s2;
	assign result.released_handle = res_rel_s2 ? rd_q : '0;
	assign result.last_result     = res_last_s2;
	assign result.hit_total       = hit_cnt_q;
	assign result.miss_total      = miss_cnt_q;
	assign result.eviction_total  = evict_cnt_q;
	assign result.failure_total   = fail_cnt_q;
	assign result.occupied_total  = occ_out_x[OCC_OUT_W-1:0];

	// Slots are filled in index order and freed together, so the occupied count
	// always matches the valid bits and never passes the slots in use.
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupied count differs from valid bits");

	a_occ_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_x <= slots_x)
		else $error("occupied count above slots in use");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acq && ins && full) |=> (occ_q == $past(occ_q)))
		else $error("eviction changed the occupied count");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fls_end |=> (occ_q == '0) && (valid_q == '0) && (ptr_q == '0))
		else $error("flush left slots occupied");

endmodule

@@ tb/fifo_assoc_handle_cache_tb.sv @@
// ----------------------------------------------------------------------------
// fifo_assoc_handle_cache_tb: self-checking bench for the handle cache
// Drives acquire and flush words through the start/busy handshake and mirrors
// the cache in a scoreboard: slot contents, oldest-first replacement, the
// running counters and the slots-in-use register. Every strobed result word is
// checked field by field, in order, against the predicted words.
// ----------------------------------------------------------------------------
module fifo_assoc_handle_cache_tb;

	import fahc_pkg::*;

	localparam int CAPACITY      = 16;
	localparam int ID_BITS       = 32;
	localparam logic [KEY_IDENTITY_W-1:0] ID_MASK =
		(ID_BITS >= KEY_IDENTITY_W) ? '1 : ((KEY_IDENTITY_W'(1) << ID_BITS) - 1);

	// Roughly this many words go out in the random part.
	localparam int RANDOM_WORDS  = 180;
	// Cycles allowed with no word accepted and no result before giving up.
	// The slowest quiet stretch is a drain wait plus a full flush, well below this.
	localparam int STALL_LIMIT   = 500;
	// Settling time after the last expected result: a full flush plus margin.
	localparam int DRAIN_CYCLES  = 20;
	localparam int POOL_DEPTH    = 24;

	// ------------------------------------------------------------------------
	// Scoreboard: a behavioral copy of the cache plus the queue of result
	// words that the copy says must come out next.
	// ------------------------------------------------------------------------
	class cache_scoreboard;
		logic [KEY_VARIANT_W-1:0]  slot_variant  [CAPACITY];
		logic [KEY_IDENTITY_W-1:0] slot_identity [CAPACITY];
		logic [HANDLE_W-1:0]       slot_handle   [CAPACITY];
		bit                        slot_full     [CAPACITY];
		int unsigned               evict_ptr;
		int unsigned               occupancy;
		int unsigned               slots_used;
		logic [COUNT_W-1:0]        hits, misses, evictions, failures;
		result_t                   expected_words[$];
		int                        errors;

		function new();
			for (int i = 0; i < CAPACITY; i++) slot_full[i] = 1'b0;
			evict_ptr  = 0;
			occupancy  = 0;
			slots_used = CAPACITY;
			hits       = '0;
			misses     = '0;
			evictions  = '0;
			failures   = '0;
			errors     = 0;
		endfunction

		// The register only takes effect on an empty cache; out-of-range
		// values clamp to the legal span.
		function void configure(logic [SLOTS_CFG_W-1:0] value);
			int unsigned v;
			if (occupancy != 0) return;
			v = 32'(value);
			if (v < 1) v = 1;
			if (v > CAPACITY) v = CAPACITY;
			slots_used = v;
			evict_ptr  = 0;
		endfunction

		// Builds one result word carrying the counters as they stand now.
		function result_t outcome(bit succ, bit hit, logic [HANDLE_W-1:0] hout,
				bit rel, logic [HANDLE_W-1:0] rhandle, bit last);
			result_t r;
			r.success         = succ;
			r.was_hit         = hit;
			r.handle_out      = hout;
			r.released_valid  = rel;
			r.released_handle = rhandle;
			r.last_result     = last;
			r.hit_total       = hits;
			r.miss_total      = misses;
			r.eviction_total  = evictions;
			r.failure_total   = failures;
			r.occupied_total  = occupancy[OCC_OUT_W-1:0];
			return r;
		endfunction

		function void note(item_t w);
			logic [KEY_IDENTITY_W-1:0] ident;
			logic [HANDLE_W-1:0]       dropped;
			bit                        released;
			int unsigned               slot;
			int                        emitted;
			ident = w.key_identity & ID_MASK;

			if (w.operation == OP_FLUSH) begin
				occupancy = 0;
				evict_ptr = 0;
				emitted   = 0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (slot_full[i]) begin
						slot_full[i] = 1'b0;
						expected_words.push_back(outcome(0, 0, '0, 1, slot_handle[i], 0));
						emitted++;
					end
				end
				if (emitted == 0)
					expected_words.push_back(outcome(0, 0, '0, 0, '0, 1));
				else
					expected_words[expected_words.size() - 1].last_result = 1'b1;
				return;
			end

			for (int i = 0; i < slots_used; i++) begin
				if (slot_full[i] && slot_variant[i] == w.key_variant &&
						slot_identity[i] == ident) begin
					hits++;
					expected_words.push_back(outcome(1, 1, slot_handle[i], 0, '0, 1));
					return;
				end
			end

			if (!w.create_ok) begin
				failures++;
				expected_words.push_back(outcome(0, 0, '0, 0, '0, 1));
				return;
			end

			misses++;
			released = 1'b0;
			dropped  = '0;
			if (occupancy < slots_used) begin
				slot = occupancy;
			end else begin
				slot = evict_ptr;
				if (slot >= slots_used) slot = 0;
				released        = 1'b1;
				dropped         = slot_handle[slot];
				slot_full[slot] = 1'b0;
				occupancy--;
				evictions++;
				evict_ptr = slot + 1;
				if (evict_ptr >= slots_used) evict_ptr = 0;
			end
			slot_variant[slot]  = w.key_variant;
			slot_identity[slot] = ident;
			slot_handle[slot]   = w.new_handle;
			slot_full[slot]     = 1'b1;
			occupancy++;
			expected_words.push_back(outcome(1, 0, w.new_handle, released, dropped, 1));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check(result_t got);
			result_t want;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("success",         32'(want.success),         32'(got.success));
			compare_field("was_hit",         32'(want.was_hit),         32'(got.was_hit));
			compare_field("handle_out",      want.handle_out,           got.handle_out);
			compare_field("released_valid",  32'(want.released_valid),
				32'(got.released_valid));
			compare_field("released_handle", want.released_handle,      got.released_handle);
			compare_field("last_result",     32'(want.last_result),     32'(got.last_result));
			compare_field("hit_total",       want.hit_total,            got.hit_total);
			compare_field("miss_total",      want.miss_total,           got.miss_total);
			compare_field("eviction_total",  want.eviction_total,       got.eviction_total);
			compare_field("failure_total",   want.failure_total,        got.failure_total);
			compare_field("occupied_total",  32'(want.occupied_total),
				32'(got.occupied_total));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	item_t                  item;
	logic                   done;
	result_t                result;
	logic                   cfg_we;
	logic [SLOTS_CFG_W-1:0] cfg_wdata;

	cache_scoreboard sb = new();

	// When set, the sender never inserts gaps between words.
	bit steady;

	fifo_assoc_handle_cache #(
		.CAPACITY      (CAPACITY),
		.IDENTITY_BITS (ID_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Results cannot be held off, so every strobe is checked at the edge that
	// ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) sb.check(result);
	end

	// Watchdog: a hung handshake or a lost result shows up as a long run of
	// cycles in which nothing moves in either direction.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_we) quiet = 0;
			else quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Sends one word. The sender sometimes idles first; start then stays high
	// until the word is taken, and is left high so back-to-back words need
	// no second assignment in the acceptance step.
	task automatic issue(input item_t w);
		if (!steady && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		sb.note(w);
	endtask

	task automatic acquire(input logic [KEY_VARIANT_W-1:0] key_v,
			input logic [KEY_IDENTITY_W-1:0] key_id, input bit ok,
			input logic [HANDLE_W-1:0] handle);
		item_t w;
		w.operation    = OP_ACQUIRE;
		w.key_variant  = key_v;
		w.key_identity = key_id;
		w.create_ok    = ok;
		w.new_handle   = handle;
		issue(w);
	endtask

	// A flush ignores the key and handle fields, so they carry noise.
	task automatic flush_all();
		item_t w;
		w.operation    = OP_FLUSH;
		w.key_variant  = KEY_VARIANT_W'($urandom_range(255));
		w.key_identity = $urandom;
		w.create_ok    = 1'($urandom_range(1));
		w.new_handle   = $urandom;
		issue(w);
	endtask

	// Lets every expected result arrive and the block settle. Every word
	// yields at least one result, so an empty queue plus a short margin
	// means the block is idle.
	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (sb.expected_words.size() != 0);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_slots(input logic [SLOTS_CFG_W-1:0] value);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.configure(value);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [KEY_VARIANT_W-1:0]  pool_variant  [POOL_DEPTH];
		logic [KEY_IDENTITY_W-1:0] pool_identity [POOL_DEPTH];
		int sent, phase, length, pool_size, pick, k;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		steady    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, full capacity after reset.
		// A flush of an empty cache gives one word with nothing released.
		flush_all();
		// All-ones key and handle: a plain miss, then a hit that ignores the
		// failed create and the new handle.
		acquire(8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		acquire(8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
		// All-zero key with a failed create only bumps the failure count.
		acquire(8'h00, 32'h0000_0000, 1'b0, 32'hDEAD_BEEF);
		// Same identity but another variant, and the reverse, must both miss.
		acquire(8'h00, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
		acquire(8'hFF, 32'h0000_0000, 1'b1, 32'h1234_5678);
		flush_all();

		// Two slots: the third distinct key evicts the oldest, and the
		// replace pointer wraps.
		write_slots(5'd2);
		acquire(8'h11, 32'hA5A5_0001, 1'b1, 32'h0000_00A1);
		acquire(8'h22, 32'hA5A5_0002, 1'b1, 32'h0000_00A2);
		acquire(8'h33, 32'hA5A5_0003, 1'b1, 32'h0000_00A3);
		acquire(8'h33, 32'hA5A5_0003, 1'b1, 32'h0000_0BAD);
		acquire(8'h11, 32'hA5A5_0001, 1'b1, 32'h0000_00B1);
		// A register write while entries are held must be dropped.
		write_slots(5'd0);
		acquire(8'h44, 32'hA5A5_0004, 1'b1, 32'h0000_00A4);
		flush_all();

		// Zero clamps to a single slot, where every new key after the first evicts.
		write_slots(5'd0);
		acquire(8'h11, 32'h5A5A_0001, 1'b1, 32'h0000_00C1);
		acquire(8'h22, 32'h5A5A_0002, 1'b1, 32'h0000_00C2);
		acquire(8'h22, 32'h5A5A_0002, 1'b0, 32'h0000_00C3);
		flush_all();

		// Random part. Each phase picks a register value (ignored if the
		// previous phase left entries behind) and a small key pool so that
		// hits, refills and evictions all happen often.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(5))
				0:       write_slots(5'd1);
				1:       write_slots(5'd16);
				2:       write_slots(5'd0);
				3:       write_slots(5'd31);
				default: write_slots(SLOTS_CFG_W'($urandom_range(31)));
			endcase
			// One long phase runs with no sender gaps at all.
			steady    = (phase == 1);
			length    = steady ? 40 : $urandom_range(10, 35);
			pool_size = $urandom_range(3, POOL_DEPTH);
			for (int i = 0; i < POOL_DEPTH; i++) begin
				pool_variant[i]  = KEY_VARIANT_W'($urandom_range(255));
				pool_identity[i] = $urandom;
				// Near-miss keys that share one half of a neighbor's key.
				if (i > 0 && $urandom_range(3) == 0) begin
					if ($urandom_range(1)) pool_identity[i] = pool_identity[i-1];
					else pool_variant[i] = pool_variant[i-1];
				end
			end
			for (int n = 0; n < length; n++) begin
				// Now and then hold back until the cache has answered everything.
				if (!steady && $urandom_range(99) < 3) wait_quiet();
				pick = $urandom_range(99);
				if (pick < 5) begin
					flush_all();
				end else if (pick < 10) begin
					acquire(KEY_VARIANT_W'($urandom_range(255)), $urandom,
						$urandom_range(99) >= 10, $urandom);
				end else begin
					k = $urandom_range(pool_size - 1);
					acquire(pool_variant[k], pool_identity[k], $urandom_range(99) >= 10,
						$urandom);
				end
				sent++;
			end
			// Usually empty the cache so the next register value can land.
			if ($urandom_range(99) < 70) begin
				flush_all();
				sent++;
			end
			phase++;
		end
		steady = 1'b0;

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/fahc_pkg.sv
rtl/core/fahc_ctrl.sv
rtl/core/fahc_dp.sv
rtl/core/fifo_assoc_handle_cache.sv
tb/fifo_assoc_handle_cache_tb.sv
